// File: rtl/yfdtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package yfdtd_pkg;

    // fixed field widths
    localparam int VAL_W   = 32;
    localparam int CW      = 2 * VAL_W;
    localparam int CMD_W   = 2;
    localparam int COORD_W = 4;
    localparam int COMP_W  = 3;
    localparam int KIND_W  = 2;
    localparam int NMEM    = 6;
    localparam int NUM_E   = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // field components, also the memory numbering
    localparam logic [COMP_W-1:0] COMP_EX = 3'd0;
    localparam logic [COMP_W-1:0] COMP_EY = 3'd1;
    localparam logic [COMP_W-1:0] COMP_EZ = 3'd2;
    localparam logic [COMP_W-1:0] COMP_HX = 3'd3;
    localparam logic [COMP_W-1:0] COMP_HY = 3'd4;
    localparam logic [COMP_W-1:0] COMP_HZ = 3'd5;

    localparam logic [31:0] H_COEFF_RST = 32'd65536;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    // clamp a wide signed value into 32 bits
    function automatic logic signed [VAL_W-1:0] sat64(logic signed [63:0] v);
        logic signed [VAL_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    // real part in the upper half, imaginary in the lower
    function automatic logic signed [VAL_W-1:0] part_of(logic [CW-1:0] v, logic p);
        logic signed [VAL_W-1:0] r;
        r = p ? v[CW-1:VAL_W] : v[VAL_W-1:0];
        return r;
    endfunction

    // exact a - b - c + d
    function automatic logic signed [VAL_W+1:0] curl4(logic signed [VAL_W-1:0] a,
                                                      logic signed [VAL_W-1:0] b,
                                                      logic signed [VAL_W-1:0] c,
                                                      logic signed [VAL_W-1:0] d);
        logic signed [VAL_W+1:0] r;
        r = 34'(a) - 34'(b) - 34'(c) + 34'(d);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/yfdtd_field_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module yfdtd_field_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic [yfdtd_pkg::CW-1:0] i_wdata,
    input  wire logic [AW-1:0]           i_raddr_a,
    input  wire logic [AW-1:0]           i_raddr_b,
    output logic      [yfdtd_pkg::CW-1:0] o_rdata_a,
    output logic      [yfdtd_pkg::CW-1:0] o_rdata_b
);
    import yfdtd_pkg::*;

    logic [CW-1:0] r_mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// File: rtl/yee_fdtd_grid_stepper_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Yee-grid FDTD stepper holding six complex Q16.16 field grids in six two-read-port
// memories. A step command sweeps the interior cells twice, once for H and once for E
// (each source grid needs three reads per cell over two read ports), then adds the
// source to the centre Ez and returns it. After reset the block runs the clearing pass
// that a clear command runs, with in_ready low; h_coeff writes are taken at any time.
// One command is worked on at a time; the next is accepted while the previous result
// still waits at the output.

module yee_fdtd_grid_stepper_top #(
    parameter int GRID_X    = 16,
    parameter int GRID_Y    = 16,
    parameter int GRID_Z    = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [yfdtd_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic signed [yfdtd_pkg::VAL_W-1:0] i_src_re,
    input  wire logic signed [yfdtd_pkg::VAL_W-1:0] i_src_im,
    input  wire logic [yfdtd_pkg::COORD_W-1:0]  i_cell_x,
    input  wire logic [yfdtd_pkg::COORD_W-1:0]  i_cell_y,
    input  wire logic [yfdtd_pkg::COORD_W-1:0]  i_cell_z,
    input  wire logic [yfdtd_pkg::COMP_W-1:0]   i_component,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [yfdtd_pkg::VAL_W-1:0]  o_value_re,
    output logic signed [yfdtd_pkg::VAL_W-1:0]  o_value_im,
    output logic [yfdtd_pkg::KIND_W-1:0]        o_result_kind,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [31:0]                    i_cfg_data
);
    import yfdtd_pkg::*;

    localparam int NCELL = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = $clog2(NCELL);
    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int ZW    = $clog2(GRID_Z);
    localparam int PLANE = GRID_Y * GRID_Z;

    localparam logic [AW-1:0] OFS_Z   = AW'(1);
    localparam logic [AW-1:0] OFS_Y   = AW'(GRID_Z);
    localparam logic [AW-1:0] OFS_X   = AW'(PLANE);
    localparam logic [AW-1:0] W_START = AW'(PLANE + GRID_Z + 1);
    localparam logic [AW-1:0] STEP_Y  = AW'(3);
    localparam logic [AW-1:0] STEP_X  = AW'(2 * GRID_Z + 3);
    localparam logic [AW-1:0] CENTRE  =
        AW'((GRID_X / 2) * PLANE + (GRID_Y / 2) * GRID_Z + GRID_Z / 2);
    localparam logic [AW-1:0] LAST    = AW'(NCELL - 1);
    localparam logic [XW-1:0] X_END   = XW'(GRID_X - 2);
    localparam logic [YW-1:0] Y_END   = YW'(GRID_Y - 2);
    localparam logic [ZW-1:0] Z_END   = ZW'(GRID_Z - 2);
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [10:0] {
        S_CLR  = 11'b000_0000_0001,
        S_IDLE = 11'b000_0000_0010,
        S_HSW  = 11'b000_0000_0100,
        S_HDRN = 11'b000_0000_1000,
        S_ESW  = 11'b000_0001_0000,
        S_EDRN = 11'b000_0010_0000,
        S_SRD  = 11'b000_0100_0000,
        S_SWR  = 11'b000_1000_0000,
        S_RRD  = 11'b001_0000_0000,
        S_RWT  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    logic [31:0]           r_h_coeff;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_clr_reply;
    logic [AW-1:0]         r_w;
    logic [XW-1:0]         r_cx;
    logic [YW-1:0]         r_cy;
    logic [ZW-1:0]         r_cz;
    logic                  r_ph;
    logic [AW-1:0]         r_rd_addr;
    logic [COMP_W-1:0]     r_comp;
    logic [CW-1:0]         r_src;
    logic [CW-1:0]         r_res;
    logic [KIND_W-1:0]     r_res_kind;

    // memory ports
    logic [AW-1:0] addr_a [NMEM];
    logic [AW-1:0] addr_b [NMEM];
    logic [CW-1:0] q_a    [NMEM];
    logic [CW-1:0] q_b    [NMEM];
    logic          we     [NMEM];
    logic [AW-1:0] waddr  [NMEM];
    logic [CW-1:0] wdata  [NMEM];

    // pipeline
    logic [CW-1:0]              r_qa0 [NMEM];
    logic [CW-1:0]              r_qb0 [NMEM];
    logic                       r_v_q1;
    logic [AW-1:0]              r_p_addr;
    logic                       r_p_h;
    logic                       r_s1_v, r_s2_v, r_s3_v;
    logic                       r_s1_h, r_s2_h, r_s3_h;
    logic [AW-1:0]              r_s1_addr, r_s2_addr, r_s3_addr;
    logic signed [VAL_W+1:0]    r_s1_curl [NUM_E][2];
    logic [CW-1:0]              r_s1_old  [NUM_E];
    logic signed [63:0]         r_s2_prod [NUM_E][2];
    logic [CW-1:0]              r_s2_old  [NUM_E];
    logic signed [63:0]         r_s3_sc   [NUM_E][2];
    logic [CW-1:0]              r_s3_old  [NUM_E];

    logic signed [VAL_W+1:0]    curl      [NUM_E][2];
    logic [CW-1:0]              old_tgt   [NUM_E];
    logic signed [63:0]         prod      [NUM_E][2];
    logic [CW-1:0]              enew      [NUM_E];
    logic [CW-1:0]              hnew      [NUM_E];
    logic [CW-1:0]              src_sum;
    logic                       pipe_busy;
    logic                       rd_ok;
    logic [AW-1:0]              rd_addr;
    logic                       last_cell;
    logic                       in_acc;
    logic                       in_h, in_e;
    t_state                     n_state;

    // neighbour addresses of the current cell
    logic [AW-1:0] bk, fr, bt, tp, lf, rt;
    assign bk = r_w - OFS_Z;
    assign fr = r_w + OFS_Z;
    assign bt = r_w - OFS_Y;
    assign tp = r_w + OFS_Y;
    assign lf = r_w - OFS_X;
    assign rt = r_w + OFS_X;

    assign in_h      = (r_state == S_HSW);
    assign in_e      = (r_state == S_ESW);
    assign in_acc    = i_in_valid && o_in_ready;
    assign pipe_busy = r_v_q1 || r_s1_v || r_s2_v || r_s3_v;
    assign last_cell = (r_cx == X_END) && (r_cy == Y_END) && (r_cz == Z_END);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // read request check and address
    assign rd_ok = (int'(i_cell_x) < GRID_X) && (int'(i_cell_y) < GRID_Y)
                && (int'(i_cell_z) < GRID_Z) && (i_component <= COMP_HZ);
    assign rd_addr = AW'(int'(i_cell_x) * PLANE + int'(i_cell_y) * GRID_Z
                       + int'(i_cell_z));

    // read address selection: source grids read two neighbours in phase 0/1
    always_comb begin
        addr_b[COMP_EX] = bk;
        addr_b[COMP_EY] = bk;
        addr_b[COMP_EZ] = bt;
        addr_b[COMP_HX] = fr;
        addr_b[COMP_HY] = fr;
        addr_b[COMP_HZ] = tp;
        for (int m = 0; m < NMEM; m++) begin
            addr_a[m] = r_rd_addr;
        end
        if (in_h || in_e) begin
            for (int m = 0; m < NMEM; m++) begin
                addr_a[m] = r_w;
            end
            if (r_ph && in_h) begin
                addr_a[COMP_EX] = bt;
                addr_a[COMP_EY] = lf;
                addr_a[COMP_EZ] = lf;
            end
            if (r_ph && in_e) begin
                addr_a[COMP_HX] = tp;
                addr_a[COMP_HY] = rt;
                addr_a[COMP_HZ] = rt;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NMEM; g++) begin : g_mem
            yfdtd_field_ram #(.DEPTH(NCELL), .AW(AW)) u_ram (
                .i_clk     (i_clk),
                .i_we      (we[g]),
                .i_waddr   (waddr[g]),
                .i_wdata   (wdata[g]),
                .i_raddr_a (addr_a[g]),
                .i_raddr_b (addr_b[g]),
                .o_rdata_a (q_a[g]),
                .o_rdata_b (q_b[g])
            );
        end
    endgenerate

    // stage 1: curl from phase-0 words (held) and phase-1 words (on the port)
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            if (r_p_h) begin
                curl[0][p] = curl4(part_of(r_qa0[COMP_EY], 1'(p)), part_of(r_qb0[COMP_EY], 1'(p)),
                                   part_of(r_qa0[COMP_EZ], 1'(p)), part_of(r_qb0[COMP_EZ], 1'(p)));
                curl[1][p] = curl4(part_of(r_qa0[COMP_EZ], 1'(p)), part_of(q_a[COMP_EZ], 1'(p)),
                                   part_of(r_qa0[COMP_EX], 1'(p)), part_of(r_qb0[COMP_EX], 1'(p)));
                curl[2][p] = curl4(part_of(r_qa0[COMP_EX], 1'(p)), part_of(q_a[COMP_EX], 1'(p)),
                                   part_of(r_qa0[COMP_EY], 1'(p)), part_of(q_a[COMP_EY], 1'(p)));
            end else begin
                curl[0][p] = curl4(part_of(r_qb0[COMP_HZ], 1'(p)), part_of(r_qa0[COMP_HZ], 1'(p)),
                                   part_of(r_qb0[COMP_HY], 1'(p)), part_of(r_qa0[COMP_HY], 1'(p)));
                curl[1][p] = curl4(part_of(r_qb0[COMP_HX], 1'(p)), part_of(r_qa0[COMP_HX], 1'(p)),
                                   part_of(q_a[COMP_HZ], 1'(p)), part_of(r_qa0[COMP_HZ], 1'(p)));
                curl[2][p] = curl4(part_of(q_a[COMP_HY], 1'(p)), part_of(r_qa0[COMP_HY], 1'(p)),
                                   part_of(q_a[COMP_HX], 1'(p)), part_of(r_qa0[COMP_HX], 1'(p)));
            end
        end
        for (int i = 0; i < NUM_E; i++) begin
            old_tgt[i] = r_p_h ? r_qa0[NUM_E + i] : r_qa0[i];
        end
    end

    // stage 2: H product by the coefficient, E sum with saturation
    always_comb begin
        logic signed [VAL_W:0]   sa;
        logic signed [VAL_W:0]   cb;
        logic signed [2*VAL_W+1:0] pr;
        cb = {1'b0, r_h_coeff};
        for (int i = 0; i < NUM_E; i++) begin
            for (int p = 0; p < 2; p++) begin
                sa = 33'(sat64(64'(r_s1_curl[i][p])));
                pr = sa * cb;
                prod[i][p] = pr[63:0];
            end
            enew[i] = {sat64(64'(part_of(r_s1_old[i], 1'b1)) + 64'(r_s1_curl[i][1])),
                       sat64(64'(part_of(r_s1_old[i], 1'b0)) + 64'(r_s1_curl[i][0]))};
        end
    end

    // stage 4: H accumulate with saturation
    always_comb begin
        for (int i = 0; i < NUM_E; i++) begin
            hnew[i] = {sat64(64'(part_of(r_s3_old[i], 1'b1)) + r_s3_sc[i][1]),
                       sat64(64'(part_of(r_s3_old[i], 1'b0)) + r_s3_sc[i][0])};
        end
    end

    // centre source add
    assign src_sum = {sat64(64'(part_of(q_a[COMP_EZ], 1'b1)) + 64'(part_of(r_src, 1'b1))),
                      sat64(64'(part_of(q_a[COMP_EZ], 1'b0)) + 64'(part_of(r_src, 1'b0)))};

    // write ports: clearing pass, sweep write-back, source write
    always_comb begin
        for (int m = 0; m < NMEM; m++) begin
            we[m]    = 1'b0;
            waddr[m] = r_s3_addr;
            wdata[m] = '0;
        end
        if (r_state == S_CLR) begin
            for (int m = 0; m < NMEM; m++) begin
                we[m]    = 1'b1;
                waddr[m] = r_clr_addr;
            end
        end else if (r_state == S_SWR) begin
            we[COMP_EZ]    = 1'b1;
            waddr[COMP_EZ] = CENTRE;
            wdata[COMP_EZ] = src_sum;
        end else if (r_s3_v) begin
            for (int i = 0; i < NUM_E; i++) begin
                if (r_s3_h) begin
                    we[NUM_E + i]    = 1'b1;
                    wdata[NUM_E + i] = hnew[i];
                end else begin
                    we[i]    = 1'b1;
                    wdata[i] = r_s3_old[i];
                end
            end
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_q1 <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_v_q1 <= (in_h || in_e) && r_ph;
            r_s1_v <= r_v_q1;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
        for (int m = 0; m < NMEM; m++) begin
            r_qa0[m] <= q_a[m];
            r_qb0[m] <= q_b[m];
        end
        r_p_addr  <= r_w;
        r_p_h     <= in_h;
        r_s1_addr <= r_p_addr;
        r_s1_h    <= r_p_h;
        r_s2_addr <= r_s1_addr;
        r_s2_h    <= r_s1_h;
        r_s3_addr <= r_s2_addr;
        r_s3_h    <= r_s2_h;
        for (int i = 0; i < NUM_E; i++) begin
            r_s1_old[i] <= old_tgt[i];
            r_s2_old[i] <= r_s1_h ? r_s1_old[i] : enew[i];
            r_s3_old[i] <= r_s2_old[i];
            for (int p = 0; p < 2; p++) begin
                r_s1_curl[i][p] <= curl[i][p];
                r_s2_prod[i][p] <= prod[i][p];
                r_s3_sc[i][p]   <= (r_s2_prod[i][p] + RND) >>> FRAC_BITS;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr_addr == LAST) n_state = r_clr_reply ? S_DONE : S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    priority case (i_cmd)
                        CMD_STEP:  n_state = S_HSW;
                        CMD_READ:  n_state = rd_ok ? S_RRD : S_DONE;
                        CMD_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_HSW:  if (r_ph && last_cell) n_state = S_HDRN;
            S_HDRN: if (!pipe_busy) n_state = S_ESW;
            S_ESW:  if (r_ph && last_cell) n_state = S_EDRN;
            S_EDRN: if (!pipe_busy) n_state = S_SRD;
            S_SRD:  n_state = S_SWR;
            S_SWR:  n_state = S_DONE;
            S_RRD:  n_state = S_RWT;
            S_RWT:  n_state = S_DONE;
            S_DONE: if (!o_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_h_coeff   <= H_COEFF_RST;
            o_out_valid <= 1'b0;
            r_ph        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_h_coeff <= i_cfg_data;
            end
            if (r_state == S_CLR) begin
                r_clr_addr <= (r_clr_addr == LAST) ? '0 : r_clr_addr + AW'(1);
            end
            if (in_acc && i_cmd == CMD_CLEAR) begin
                r_clr_reply <= 1'b1;
                r_clr_addr  <= '0;
            end
            if (in_h || in_e) begin
                r_ph <= ~r_ph;
            end else begin
                r_ph <= 1'b0;
            end
            // result word loaded, or taken by the receiver
            if (r_state == S_DONE && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // sweep counters and command data
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE && in_acc) || r_state == S_HDRN) begin
            r_cx <= XW'(1);
            r_cy <= YW'(1);
            r_cz <= ZW'(1);
            r_w  <= W_START;
        end else if ((in_h || in_e) && r_ph && !last_cell) begin
            if (r_cz == Z_END) begin
                r_cz <= ZW'(1);
                if (r_cy == Y_END) begin
                    r_cy <= YW'(1);
                    r_cx <= r_cx + XW'(1);
                    r_w  <= r_w + STEP_X;
                end else begin
                    r_cy <= r_cy + YW'(1);
                    r_w  <= r_w + STEP_Y;
                end
            end else begin
                r_cz <= r_cz + ZW'(1);
                r_w  <= r_w + OFS_Z;
            end
        end
        if (r_state == S_IDLE && in_acc) begin
            r_src      <= {i_src_re, i_src_im};
            r_comp     <= i_component;
            r_res      <= '0;
            r_res_kind <= (i_cmd == CMD_READ)  ? KIND_READ
                        : (i_cmd == CMD_CLEAR) ? KIND_CLEAR : KIND_STEP;
            r_rd_addr  <= (i_cmd == CMD_READ) ? rd_addr : CENTRE;
        end
        if (r_state == S_SWR) begin
            r_res <= src_sum;
        end
        if (r_state == S_RWT) begin
            r_res <= q_a[r_comp];
        end
        if (r_state == S_DONE && (!o_out_valid || i_out_ready)) begin
            o_value_re    <= part_of(r_res, 1'b1);
            o_value_im    <= part_of(r_res, 1'b0);
            o_result_kind <= r_res_kind;
        end
    end

    // sweep write-back only happens inside a step
    a_wb_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_v |-> (r_state == S_HSW || r_state == S_HDRN
                 || r_state == S_ESW || r_state == S_EDRN))
        else $error("field write-back outside a sweep");

    // no new command while the pipeline still holds cells
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !pipe_busy)
        else $error("input ready with sweep pipeline busy");

    // E sweep starts only after all H writes have landed
    a_e_after_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HDRN && n_state == S_ESW) |-> !r_s3_v)
        else $error("E sweep started before H sweep drained");

    // centre read sees a drained pipeline
    a_src_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRD) |-> !pipe_busy)
        else $error("source read while sweep writes pending");

endmodule

`default_nettype wire

// File: tb/tb_yfdtd_checker.sv
`timescale 1ns / 1ps

module tb_yfdtd_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic [yfdtd_pkg::CMD_W-1:0]        i_cmd,
    input  wire logic signed [yfdtd_pkg::VAL_W-1:0] i_src_re,
    input  wire logic signed [yfdtd_pkg::VAL_W-1:0] i_src_im,
    input  wire logic [yfdtd_pkg::COORD_W-1:0]      i_cell_x,
    input  wire logic [yfdtd_pkg::COORD_W-1:0]      i_cell_y,
    input  wire logic [yfdtd_pkg::COORD_W-1:0]      i_cell_z,
    input  wire logic [yfdtd_pkg::COMP_W-1:0]       i_component,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic signed [yfdtd_pkg::VAL_W-1:0] i_value_re,
    input  wire logic signed [yfdtd_pkg::VAL_W-1:0] i_value_im,
    input  wire logic [yfdtd_pkg::KIND_W-1:0]       i_result_kind,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_ready,
    input  wire logic [31:0]                        i_cfg_data,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    import yfdtd_pkg::*;

    localparam int GX = 16;
    localparam int GY = 16;
    localparam int GZ = 16;
    localparam int NCELLS = GX * GY * GZ;
    localparam int FRAC = 16;

    typedef struct {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
        logic [KIND_W-1:0]       kind;
    } t_field_word;

    // field copy: [part 0 re, 1 im][component][cell]
    logic signed [VAL_W-1:0] fields [2][NMEM][NCELLS];
    logic [31:0]             h_scale;
    t_field_word             expected_words [$];
    int                      n_pred = 0;
    int                      n_seen = 0;

    // words predicted but not yet seen at the output
    assign o_pending = n_pred - n_seen;

    function automatic int cell_idx(int x, int y, int z);
        return (x * GY + y) * GZ + z;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[VAL_W-1:0];
    endfunction

    function automatic longint diff4(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b,
                                     logic signed [VAL_W-1:0] c, logic signed [VAL_W-1:0] d);
        return longint'(a) - longint'(b) - longint'(c) + longint'(d);
    endfunction

    // h + round(h_scale * sat(curl) / 2^FRAC), ties upward, then clamp
    function automatic logic signed [VAL_W-1:0] h_bump(logic signed [VAL_W-1:0] h, longint curl);
        longint c;
        longint prod;
        c    = longint'(clamp32(curl));
        prod = c * longint'({32'd0, h_scale});
        prod = prod + (64'sd1 <<< (FRAC - 1));
        return clamp32(longint'(h) + (prod >>> FRAC));
    endfunction

    function automatic void wipe_fields();
        for (int p = 0; p < 2; p++)
            for (int m = 0; m < NMEM; m++)
                for (int w = 0; w < NCELLS; w++)
                    fields[p][m][w] = '0;
    endfunction

    // one leapfrog step over the interior, then the source at the centre
    function automatic t_field_word leapfrog(logic signed [VAL_W-1:0] sre,
                                             logic signed [VAL_W-1:0] sim);
        t_field_word r;
        int w;
        int c;
        c = cell_idx(GX / 2, GY / 2, GZ / 2);
        for (int x = 1; x < GX - 1; x++)
            for (int y = 1; y < GY - 1; y++)
                for (int z = 1; z < GZ - 1; z++) begin
                    w = cell_idx(x, y, z);
                    for (int p = 0; p < 2; p++) begin
                        fields[p][COMP_HX][w] = h_bump(fields[p][COMP_HX][w],
                            diff4(fields[p][COMP_EY][w], fields[p][COMP_EY][w-1],
                                  fields[p][COMP_EZ][w], fields[p][COMP_EZ][w-GZ]));
                        fields[p][COMP_HY][w] = h_bump(fields[p][COMP_HY][w],
                            diff4(fields[p][COMP_EZ][w], fields[p][COMP_EZ][w-GY*GZ],
                                  fields[p][COMP_EX][w], fields[p][COMP_EX][w-1]));
                        fields[p][COMP_HZ][w] = h_bump(fields[p][COMP_HZ][w],
                            diff4(fields[p][COMP_EX][w], fields[p][COMP_EX][w-GZ],
                                  fields[p][COMP_EY][w], fields[p][COMP_EY][w-GY*GZ]));
                    end
                end
        for (int x = 1; x < GX - 1; x++)
            for (int y = 1; y < GY - 1; y++)
                for (int z = 1; z < GZ - 1; z++) begin
                    w = cell_idx(x, y, z);
                    for (int p = 0; p < 2; p++) begin
                        fields[p][COMP_EX][w] = clamp32(longint'(fields[p][COMP_EX][w]) +
                            diff4(fields[p][COMP_HZ][w+GZ], fields[p][COMP_HZ][w],
                                  fields[p][COMP_HY][w+1], fields[p][COMP_HY][w]));
                        fields[p][COMP_EY][w] = clamp32(longint'(fields[p][COMP_EY][w]) +
                            diff4(fields[p][COMP_HX][w+1], fields[p][COMP_HX][w],
                                  fields[p][COMP_HZ][w+GY*GZ], fields[p][COMP_HZ][w]));
                        fields[p][COMP_EZ][w] = clamp32(longint'(fields[p][COMP_EZ][w]) +
                            diff4(fields[p][COMP_HY][w+GY*GZ], fields[p][COMP_HY][w],
                                  fields[p][COMP_HX][w+GZ], fields[p][COMP_HX][w]));
                    end
                end
        fields[0][COMP_EZ][c] = clamp32(longint'(fields[0][COMP_EZ][c]) + longint'(sre));
        fields[1][COMP_EZ][c] = clamp32(longint'(fields[1][COMP_EZ][c]) + longint'(sim));
        r.re   = fields[0][COMP_EZ][c];
        r.im   = fields[1][COMP_EZ][c];
        r.kind = KIND_STEP;
        return r;
    endfunction

    initial begin
        wipe_fields();
        h_scale      = H_COEFF_RST;
        o_fail_count = 0;
    end

    // coefficient word
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && i_cfg_ready) begin
            h_scale = i_cfg_data;
        end
    end

    // command words: predict
    always @(posedge i_clk) begin
        t_field_word r;
        int w;
        if (i_rst_n && i_in_valid && i_in_ready) begin
            r.re = '0;
            r.im = '0;
            case (i_cmd)
                CMD_STEP: begin
                    r = leapfrog(i_src_re, i_src_im);
                    expected_words.push_back(r);
                    n_pred <= n_pred + 1;
                end
                CMD_READ: begin
                    r.kind = KIND_READ;
                    if (i_component < NMEM) begin
                        w    = cell_idx(i_cell_x, i_cell_y, i_cell_z);
                        r.re = fields[0][i_component][w];
                        r.im = fields[1][i_component][w];
                    end
                    expected_words.push_back(r);
                    n_pred <= n_pred + 1;
                end
                CMD_CLEAR: begin
                    wipe_fields();
                    r.kind = KIND_CLEAR;
                    expected_words.push_back(r);
                    n_pred <= n_pred + 1;
                end
                default: ;
            endcase
        end
    end

    // result words: compare with the oldest prediction
    always @(posedge i_clk) begin
        t_field_word e;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h kind=%0d", $time,
                         i_value_re, i_value_im, i_result_kind);
                o_fail_count <= o_fail_count + 1;
            end else begin
                e = expected_words.pop_front();
                n_seen <= n_seen + 1;
                if (i_value_re !== e.re || i_value_im !== e.im || i_result_kind !== e.kind) begin
                    $display("%0t: mismatch expected re=%h im=%h kind=%0d, got re=%h im=%h kind=%0d",
                             $time, e.re, e.im, e.kind, i_value_re, i_value_im, i_result_kind);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import yfdtd_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;
    localparam logic [COMP_W-1:0] COMP_NIL6 = 3'd6;
    localparam logic [COMP_W-1:0] COMP_NIL7 = 3'd7;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CMD_W-1:0] cmd = CMD_READ;
    logic signed [VAL_W-1:0] src_re = '0;
    logic signed [VAL_W-1:0] src_im = '0;
    logic [COORD_W-1:0] cell_x = '0;
    logic [COORD_W-1:0] cell_y = '0;
    logic [COORD_W-1:0] cell_z = '0;
    logic [COMP_W-1:0] component = COMP_EX;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;
    logic [KIND_W-1:0] result_kind;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] cfg_data = '0;

    int fail_count;
    int pending;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int steps_sent = 0;
    int cfg_writes = 0;

    always #6 clk = ~clk;

    yee_fdtd_grid_stepper_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_src_re(src_re), .i_src_im(src_im),
        .i_cell_x(cell_x), .i_cell_y(cell_y), .i_cell_z(cell_z),
        .i_component(component),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_value_re(value_re), .o_value_im(value_im), .o_result_kind(result_kind),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    tb_yfdtd_checker u_check (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_src_re(src_re), .i_src_im(src_im),
        .i_cell_x(cell_x), .i_cell_y(cell_y), .i_cell_z(cell_z),
        .i_component(component),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_value_re(value_re), .i_value_im(value_im), .i_result_kind(result_kind),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // run-away guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one command word and hold it until taken
    task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] sre,
                             input logic signed [VAL_W-1:0] sim, input int x,
                             input int y, input int z, input int comp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        src_re    <= sre;
        src_im    <= sim;
        cell_x    <= COORD_W'(x);
        cell_y    <= COORD_W'(y);
        cell_z    <= COORD_W'(z);
        component <= COMP_W'(comp);
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (c == CMD_STEP) steps_sent++;
    endtask

    task automatic read_cell(input int x, input int y, input int z, input int comp);
        send_word(CMD_READ, $urandom, $urandom, x, y, z, comp);
    endtask

    task automatic random_word();
        int r;
        logic signed [VAL_W-1:0] sre;
        logic signed [VAL_W-1:0] sim;
        r   = $urandom_range(99);
        sre = $urandom;
        sim = $urandom;
        if (r < 12) begin
            if ($urandom_range(3) == 0) sre = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            send_word(CMD_STEP, sre, sim, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 16) begin
            send_word(CMD_CLEAR, sre, sim, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 20) begin
            send_word(CMD_NONE, sre, sim, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 75) begin
            // near the source, where the field is alive
            read_cell($urandom_range(10, 6), $urandom_range(10, 6), $urandom_range(10, 6),
                      $urandom_range(7));
        end else begin
            read_cell($urandom_range(15), $urandom_range(15), $urandom_range(15),
                      $urandom_range(7));
        end
    endtask

    // quiet the input and let everything drain
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_coeff(input logic [31:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        logic [31:0] coeffs [4];
        int idle_set [4];
        int stall_set [4];
        coeffs    = '{32'hffffffff, 32'd0, 32'd32768, 32'd0};
        idle_set  = '{0, 63, 0, 22};
        stall_set = '{0, 0, 63, 22};
        coeffs[3] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command, the odd cases
        send_word(CMD_CLEAR, 0, 0, 0, 0, 0, COMP_EX);
        read_cell(0, 0, 0, COMP_EX);
        read_cell(15, 15, 15, COMP_HZ);
        read_cell(8, 8, 8, COMP_NIL6);
        read_cell(15, 0, 15, COMP_NIL7);
        send_word(CMD_STEP, 32'sh7fffffff, 32'sh80000000, 0, 0, 0, COMP_EX);
        read_cell(8, 8, 8, COMP_EZ);
        send_word(CMD_STEP, 32'sh7fffffff, 32'sh80000000, 15, 15, 15, COMP_NIL7);
        read_cell(8, 8, 8, COMP_HX);
        read_cell(8, 8, 7, COMP_HY);
        read_cell(7, 8, 8, COMP_HZ);
        read_cell(8, 7, 8, COMP_EX);
        read_cell(8, 8, 9, COMP_EY);
        send_word(CMD_NONE, 32'sh7fffffff, 32'sh7fffffff, 15, 15, 15, COMP_NIL7);
        send_word(CMD_STEP, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, COMP_EX);
        read_cell(9, 8, 8, COMP_EZ);
        read_cell(8, 8, 8, COMP_NIL7);
        send_word(CMD_CLEAR, 32'sh7fffffff, 32'sh80000000, 15, 15, 15, COMP_NIL7);
        read_cell(8, 8, 8, COMP_EZ);
        send_word(CMD_STEP, 1, -1, 0, 0, 0, COMP_EX);
        read_cell(8, 8, 8, COMP_EZ);

        // random phases, a new coefficient each
        for (int ph = 0; ph < 4; ph++) begin
            write_coeff(coeffs[ph]);
            sender_idle_pct = idle_set[ph];
            recv_stall_pct  = stall_set[ph];
            if (ph == 0) begin
                // long hold-off: the block fills and stalls its input
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
                for (int k = 0; k < 6; k++) read_cell(8, 8, 8, $urandom_range(5));
            end
            for (int k = 0; k < 18; k++) random_word();
        end
        write_coeff(H_COEFF_RST);
        for (int k = 0; k < 4; k++) random_word();

        drain();
        repeat (30) @(posedge clk);
        $display("covered %0d command words (%0d steps) over %0d coefficient settings",
                 words_sent, steps_sent, cfg_writes);
        $display("with no idling, sender gaps, receiver stalls, both, and a long hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
